// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files of the disparity merge block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/core/sdm_pkg.sv -----
// Shared types and constants for the stereo disparity merge block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sdm_pkg;

  // Field and arithmetic widths
  localparam int DISP_W      = 16;
  localparam int SCALE_SHIFT = 4;
  localparam int FRAC_BITS   = 13;
  localparam int CNT_W       = 23;
  localparam int RATIO_W     = 16;
  localparam int THRESH_W    = 28;
  localparam int MODE_W      = 2;
  localparam int CFG_DATA_W  = 28;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 48;
  localparam int SQ_SUM_W    = 63;
  localparam int SQ_DROP     = 16;

  // Derived widths of the difference path
  localparam int WHOLE_W = DISP_W - SCALE_SHIFT;
  localparam int VQ_W    = WHOLE_W + FRAC_BITS;
  localparam int PROD_W  = WHOLE_W + RATIO_W + 1;
  localparam int D_W     = PROD_W + 1;
  localparam int DIFF_W  = D_W - 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int OUT_W   = DISP_W + 4 * CNT_W + SUM_W + SQ_SUM_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  // Largest whole-pixel difference that still fits after scaling back up
  localparam int DIFF_IMG_LIM = (2 ** (DISP_W - 1) - 1) >> SCALE_SHIFT;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO  = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_MODE   = 2'd2,
    CFG_EMPTY  = 2'd3
  } cfg_index_e;

  // Merge mode codes; the unused code behaves as the default merge
  localparam logic [MODE_W-1:0] MODE_DEFAULT      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONSERVATIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF_IMAGE   = 2'd2;

  // Step commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic diff;
    logic sqr;
    logic acc;
  } sdm_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/sdm_ctrl.sv -----
// Sequencer of the disparity merge block: steps one pixel through the datapath
// and owns the output word valid flag. Depends on sdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire logic             m_ready_i,
  output logic                  m_valid_o,
  output sdm_pkg::sdm_cmd_t     cmd_o
);
  import sdm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_SQR,
    ST_ACC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   acc_go;

  // The accumulate step waits until the output register is free or emptying
  assign acc_go = (state_q == ST_ACC) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_SQR;
      ST_SQR:  state_d = ST_ACC;
      ST_ACC: begin
        if (acc_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o  = (state_q == ST_IDLE);
  assign m_valid_o  = out_valid_q;

  // Step commands
  assign cmd_o.load = s_ready_o && s_valid_i;
  assign cmd_o.mul  = (state_q == ST_MUL);
  assign cmd_o.diff = (state_q == ST_DIFF);
  assign cmd_o.sqr  = (state_q == ST_SQR);
  assign cmd_o.acc  = acc_go;

endmodule

`default_nettype wire

// ----- rtl/core/sdm_datapath.sv -----
// Datapath of the disparity merge block: difference, merge choice, frame
// statistics and the output word registers. Depends on sdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdm_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sdm_pkg::sdm_cmd_t                   cmd_i,
  input  wire logic signed [sdm_pkg::DISP_W-1:0]   vert_disp_i,
  input  wire logic signed [sdm_pkg::DISP_W-1:0]   horiz_disp_i,
  input  wire logic                                frame_end_i,
  input  wire logic [sdm_pkg::RATIO_W-1:0]         ratio_i,
  input  wire logic [sdm_pkg::THRESH_W-1:0]        thresh_i,
  input  wire logic [sdm_pkg::MODE_W-1:0]          mode_i,
  input  wire logic signed [sdm_pkg::DISP_W-1:0]   empty_code_i,
  output logic signed [sdm_pkg::DISP_W-1:0]        merged_disp_o,
  output logic [sdm_pkg::CNT_W-1:0]                vert_valid_count_o,
  output logic [sdm_pkg::CNT_W-1:0]                horiz_valid_count_o,
  output logic [sdm_pkg::CNT_W-1:0]                merged_valid_count_o,
  output logic [sdm_pkg::CNT_W-1:0]                both_valid_count_o,
  output logic [sdm_pkg::SUM_W-1:0]                diff_sum_o,
  output logic [sdm_pkg::SQ_SUM_W-1:0]             diff_square_sum_o,
  output logic                                     last_out_o
);
  import sdm_pkg::*;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + CNT_W'(1);
  endfunction

  // Pixel registers
  logic signed [DISP_W-1:0] v_q, h_q;
  logic                     last_q, v_empty_q, h_empty_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [DIFF_W-1:0]        diff_q, diff_d;
  logic [SQ_W-1:0]          sq_q;
  logic signed [DISP_W-1:0] res_q, res_d;

  // Frame accumulators
  logic [CNT_W-1:0]    vert_acc_q, horiz_acc_q, merged_acc_q, both_acc_q;
  logic [CNT_W-1:0]    vert_new, horiz_new, merged_new, both_new;
  logic [SUM_W-1:0]    diff_acc_q, diff_new;
  logic [SQ_SUM_W-1:0] sq_acc_q, sq_new;
  logic [SUM_W:0]      diff_sum_ext;
  logic [SQ_SUM_W:0]   sq_sum_ext;

  // Intermediate values
  logic signed [WHOLE_W-1:0] h_whole, v_whole;
  logic signed [VQ_W-1:0]    vq;
  logic signed [D_W-1:0]     d_full, d_abs;
  logic                      both, disagree;
  logic [DIFF_W-FRAC_BITS-1:0] whole_diff;
  logic signed [DISP_W:0]    pair_sum, pair_adj;

  assign both = !v_empty_q && !h_empty_q;

  // Whole-pixel horizontal disparity times the baseline ratio
  assign h_whole = WHOLE_W'(h_q >>> SCALE_SHIFT);
  assign prod_d  = PROD_W'(h_whole) * PROD_W'($signed({1'b0, ratio_i}));

  // Absolute difference in Q.13 pixels
  assign v_whole = WHOLE_W'(v_q >>> SCALE_SHIFT);
  assign vq      = {v_whole, {FRAC_BITS{1'b0}}};
  assign d_full  = D_W'(vq) - D_W'(prod_q);
  assign d_abs   = d_full[D_W-1] ? -d_full : d_full;
  assign diff_d  = DIFF_W'(d_abs);

  // Merge choice from the registered difference
  assign disagree   = diff_q > DIFF_W'(thresh_i);
  assign whole_diff = diff_q[DIFF_W-1:FRAC_BITS];
  assign pair_sum   = (DISP_W+1)'(h_q) + (DISP_W+1)'(v_q);
  assign pair_adj   = pair_sum + $signed({{DISP_W{1'b0}}, pair_sum[DISP_W]});

  always_comb begin
    res_d = empty_code_i;
    if (mode_i == MODE_CONSERVATIVE) begin
      if (both && !disagree) begin
        res_d = h_q;
      end
    end else begin
      priority if (h_empty_q) begin
        res_d = v_empty_q ? empty_code_i : v_q;
      end else if (!v_empty_q) begin
        res_d = disagree ? empty_code_i : DISP_W'(pair_adj >>> 1);
      end else begin
        res_d = h_q;
      end
      // Difference image: the whole-pixel difference, back at input scale
      if (mode_i == MODE_DIFF_IMAGE && both) begin
        if (whole_diff > (DIFF_W-FRAC_BITS)'(DIFF_IMG_LIM)) begin
          res_d = DISP_W'(2 ** (DISP_W - 1) - 1);
        end else begin
          res_d = $signed(DISP_W'(whole_diff) << SCALE_SHIFT);
        end
      end
    end
  end

  // Accumulator updates with saturation
  assign diff_sum_ext = {1'b0, diff_acc_q} + (SUM_W+1)'(diff_q);
  assign sq_sum_ext   = {1'b0, sq_acc_q} + (SQ_SUM_W+1)'(sq_q[SQ_W-1:SQ_DROP]);

  always_comb begin
    vert_new   = v_empty_q ? vert_acc_q : cnt_inc(vert_acc_q);
    horiz_new  = h_empty_q ? horiz_acc_q : cnt_inc(horiz_acc_q);
    both_new   = both ? cnt_inc(both_acc_q) : both_acc_q;
    merged_new = (res_q != empty_code_i) ? cnt_inc(merged_acc_q) : merged_acc_q;
    diff_new   = diff_acc_q;
    sq_new     = sq_acc_q;
    if (both) begin
      diff_new = diff_sum_ext[SUM_W] ? {SUM_W{1'b1}} : diff_sum_ext[SUM_W-1:0];
      sq_new   = sq_sum_ext[SQ_SUM_W] ? {SQ_SUM_W{1'b1}} : sq_sum_ext[SQ_SUM_W-1:0];
    end
  end

  // Pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q       <= vert_disp_i;
      h_q       <= horiz_disp_i;
      last_q    <= frame_end_i;
      v_empty_q <= (vert_disp_i == empty_code_i);
      h_empty_q <= (horiz_disp_i == empty_code_i);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.diff) begin
      diff_q <= diff_d;
    end
    if (cmd_i.sqr) begin
      sq_q  <= SQ_W'(diff_q) * SQ_W'(diff_q);
      res_q <= res_d;
    end
  end

  // Output word registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      merged_disp_o        <= res_q;
      vert_valid_count_o   <= vert_new;
      horiz_valid_count_o  <= horiz_new;
      merged_valid_count_o <= merged_new;
      both_valid_count_o   <= both_new;
      diff_sum_o           <= diff_new;
      diff_square_sum_o    <= sq_new;
      last_out_o           <= last_q;
    end
  end

  // Frame accumulators, cleared after the last pixel of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_acc_q   <= '0;
      horiz_acc_q  <= '0;
      merged_acc_q <= '0;
      both_acc_q   <= '0;
      diff_acc_q   <= '0;
      sq_acc_q     <= '0;
    end else if (cmd_i.acc) begin
      if (last_q) begin
        vert_acc_q   <= '0;
        horiz_acc_q  <= '0;
        merged_acc_q <= '0;
        both_acc_q   <= '0;
        diff_acc_q   <= '0;
        sq_acc_q     <= '0;
      end else begin
        vert_acc_q   <= vert_new;
        horiz_acc_q  <= horiz_new;
        merged_acc_q <= merged_new;
        both_acc_q   <= both_new;
        diff_acc_q   <= diff_new;
        sq_acc_q     <= sq_new;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/stereo_disparity_merge.sv -----
// Top level of the stereo disparity merge block: stream ports, configuration
// registers, sequencer and datapath. Depends on sdm_pkg, sdm_ctrl, sdm_datapath.
//
//   Channel   Direction  Word contents
//   s_axis    in         tdata: vert_disp, horiz_disp; tlast: frame_end
//   m_axis    out        tdata: merged_disp, four counts, two sums; tlast: last_out
//   cfg       in         write enable, register index, write data
//
// A pixel goes through the steps accept, multiply, difference, square, accumulate.
// The sequencer runs one pixel at a time through the datapath.
// The accumulate step holds while the output register is still full and unread.
// A new pixel is accepted while the previous result waits on m_axis.
// Reset clears the sequencer, the output valid flag and the frame statistics.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stereo_disparity_merge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: vert_disp [15:0], horiz_disp [31:16]
  input  wire logic [31:0]                       s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: merged_disp [15:0], vert_valid_count [38:16],
  // horiz_valid_count [61:39], merged_valid_count [84:62],
  // both_valid_count [107:85], diff_sum [155:108], diff_square_sum [218:156],
  // zero fill [223:219]
  output logic [sdm_pkg::OUT_BYTES_W-1:0]        m_axis_tdata_o,
  output logic                                   m_axis_tlast_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [sdm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [sdm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import sdm_pkg::*;

  logic [RATIO_W-1:0]       ratio_q;
  logic [THRESH_W-1:0]      thresh_q;
  logic [MODE_W-1:0]        mode_q;
  logic signed [DISP_W-1:0] empty_q;
  sdm_cmd_t                 cmd;

  logic signed [DISP_W-1:0] merged_disp;
  logic [CNT_W-1:0]         vert_cnt, horiz_cnt, merged_cnt, both_cnt;
  logic [SUM_W-1:0]         diff_sum;
  logic [SQ_SUM_W-1:0]      sq_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q  <= RATIO_W'(8192);
      thresh_q <= THRESH_W'(8192);
      mode_q   <= MODE_DEFAULT;
      empty_q  <= DISP_W'(16'h8000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_RATIO:  ratio_q  <= cfg_wdata_i[RATIO_W-1:0];
        CFG_THRESH: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        CFG_MODE:   mode_q   <= cfg_wdata_i[MODE_W-1:0];
        CFG_EMPTY:  empty_q  <= cfg_wdata_i[DISP_W-1:0];
        default:    ;
      endcase
    end
  end

  sdm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd)
  );

  sdm_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .vert_disp_i          (s_axis_tdata_i[DISP_W-1:0]),
    .horiz_disp_i         (s_axis_tdata_i[2*DISP_W-1:DISP_W]),
    .frame_end_i          (s_axis_tlast_i),
    .ratio_i              (ratio_q),
    .thresh_i             (thresh_q),
    .mode_i               (mode_q),
    .empty_code_i         (empty_q),
    .merged_disp_o        (merged_disp),
    .vert_valid_count_o   (vert_cnt),
    .horiz_valid_count_o  (horiz_cnt),
    .merged_valid_count_o (merged_cnt),
    .both_valid_count_o   (both_cnt),
    .diff_sum_o           (diff_sum),
    .diff_square_sum_o    (sq_sum),
    .last_out_o           (m_axis_tlast_o)
  );

  // Output word packing, first field in the lowest bits
  assign m_axis_tdata_o = OUT_BYTES_W'({sq_sum, diff_sum, both_cnt, merged_cnt,
                                         horiz_cnt, vert_cnt, merged_disp});

  // Checks on the sequencer
  `ASSERT_CLK(a_load_then_mul, cmd.load |=> cmd.mul, "pixel accepted but multiply step missed")
  `ASSERT_CLK(a_steps_in_order, cmd.mul |=> cmd.diff ##1 cmd.sqr, "pipeline steps out of order")
  `ASSERT_CLK(a_acc_gives_word, cmd.acc |=> m_axis_tvalid_o, "accumulate step left no output word")
  `ASSERT_NEVER(a_one_step, !$onehot0({cmd.load, cmd.mul, cmd.diff, cmd.sqr, cmd.acc}), "two steps at once")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for stereo_disparity_merge: directed table, then random frames.
// Depends on sdm_pkg and the stereo_disparity_merge top level; an internal predictor
// works out every merged word and its frame statistics.
`timescale 1ns / 1ps

module tb;
  import sdm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_PAUSE = 8;
  localparam int REPORT_MAX  = 10;
  localparam int N_DIRECTED  = 31;
  localparam int N_PHASES    = 11;

  // The unused mode code has no name in the package.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam longint unsigned CNT_SAT = (64'd1 << CNT_W) - 1;
  localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;
  localparam longint unsigned SQ_SAT  = (64'd1 << SQ_SUM_W) - 1;

  // One merged word as it leaves the block.
  typedef struct packed {
    logic [DISP_W-1:0]   merged;
    logic [CNT_W-1:0]    vert_cnt;
    logic [CNT_W-1:0]    horiz_cnt;
    logic [CNT_W-1:0]    merged_cnt;
    logic [CNT_W-1:0]    both_cnt;
    logic [SUM_W-1:0]    diff_sum;
    logic [SQ_SUM_W-1:0] sq_sum;
    logic                last;
  } merge_word_t;

  // One row of the directed table: a register write or a pixel.
  typedef struct packed {
    logic                  is_write;
    cfg_index_e            idx;
    logic [CFG_DATA_W-1:0] value;
    logic [DISP_W-1:0]     vert;
    logic [DISP_W-1:0]     horiz;
    logic                  last;
    logic                  typed;
    logic [DISP_W-1:0]     merged;
  } step_row_t;

  // Columns: write, register, value, vert, horiz, frame end, typed, merged.
  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    // Default merge with reset settings: empty handling, agreement, truncation.
    '{1'b0, CFG_RATIO, 28'd0, 16'h8000, 16'h8000, 1'b0, 1'b1, 16'h8000},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0064, 16'h8000, 1'b0, 1'b1, 16'h0064},
    '{1'b0, CFG_RATIO, 28'd0, 16'h8000, 16'h00C8, 1'b0, 1'b1, 16'h00C8},
    '{1'b0, CFG_RATIO, 28'd0, 16'h00A0, 16'h00A0, 1'b0, 1'b0, 16'h0000},
    '{1'b0, CFG_RATIO, 28'd0, 16'h7FFF, 16'h8001, 1'b0, 1'b1, 16'h8000},
    '{1'b0, CFG_RATIO, 28'd0, 16'hFFFD, 16'h0000, 1'b0, 1'b1, 16'hFFFF},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0011, 16'h0000, 1'b0, 1'b1, 16'h0008},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0020, 16'h0000, 1'b1, 1'b1, 16'h8000},
    // Conservative merge.
    '{1'b1, CFG_MODE, 28'(MODE_CONSERVATIVE), 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h00A0, 16'h00B0, 1'b0, 1'b1, 16'h00B0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0064, 16'h8000, 1'b0, 1'b1, 16'h8000},
    '{1'b0, CFG_RATIO, 28'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    // Difference image, including its saturation.
    '{1'b1, CFG_MODE, 28'(MODE_DIFF_IMAGE), 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h7FFF, 16'h8001, 1'b0, 1'b1, 16'h7FFF},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0030, 16'h0010, 1'b0, 1'b1, 16'h0020},
    '{1'b0, CFG_RATIO, 28'd0, 16'h8000, 16'h0032, 1'b1, 1'b1, 16'h0032},
    // The unused mode code behaves as the default merge.
    '{1'b1, CFG_MODE, 28'(MODE_UNUSED), 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h00A0, 16'h00A0, 1'b0, 1'b0, 16'h0000},
    // Zero as the empty code makes the most negative disparity a valid one.
    '{1'b1, CFG_EMPTY, 28'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{1'b0, CFG_RATIO, 28'd0, 16'h8000, 16'h0000, 1'b0, 1'b1, 16'h8000},
    // Lowest ratio and threshold.
    '{1'b1, CFG_RATIO, 28'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, CFG_THRESH, 28'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h0008, 16'h7FFF, 1'b0, 1'b1, 16'h4003},
    // Highest ratio and threshold.
    '{1'b1, CFG_RATIO, 28'hFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, CFG_THRESH, 28'hFFFFFFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b1, CFG_MODE, 28'(MODE_DEFAULT), 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'h8000},
    // Largest empty code.
    '{1'b1, CFG_EMPTY, 28'h7FFF, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0},
    '{1'b0, CFG_RATIO, 28'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{1'b0, CFG_RATIO, 28'd0, 16'h7FFF, 16'h0064, 1'b1, 1'b1, 16'h0064}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic [31:0]            pix_data;
  logic                   pix_last;
  logic                   pix_valid;
  logic                   pix_ready;
  logic                   pix_typed;
  logic [DISP_W-1:0]      pix_typed_merged;
  logic [OUT_BYTES_W-1:0] res_data;
  logic                   res_last;
  logic                   res_valid;
  logic                   res_ready;
  logic                   cfg_we;
  cfg_index_e             cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow of the configuration registers, at their reset values.
  logic [RATIO_W-1:0]       cfg_ratio  = 16'd8192;
  logic [THRESH_W-1:0]      cfg_thresh = 28'd8192;
  logic [MODE_W-1:0]        cfg_mode   = MODE_DEFAULT;
  logic signed [DISP_W-1:0] cfg_empty  = 16'sh8000;

  // Running frame statistics of the predictor.
  longint unsigned n_vert_valid   = 0;
  longint unsigned n_horiz_valid  = 0;
  longint unsigned n_merged_valid = 0;
  longint unsigned n_both_valid   = 0;
  longint unsigned diff_total     = 0;
  longint unsigned diff_sq_total  = 0;

  merge_word_t pending_words[$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          send_idle    = 1'b1;
  bit          recv_idle    = 1'b1;

  stereo_disparity_merge i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (pix_data),
    .s_axis_tlast_i  (pix_last),
    .s_axis_tvalid_i (pix_valid),
    .s_axis_tready_o (pix_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tlast_o  (res_last),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_wdata_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned bump_count(longint unsigned c);
    return (c < CNT_SAT) ? c + 1 : CNT_SAT;
  endfunction

  function automatic longint unsigned sat_accumulate(longint unsigned a, longint unsigned b,
                                                     longint unsigned lim);
    if (b > lim - a) return lim;
    return a + b;
  endfunction

  // Merges one pixel pair, updates the frame statistics and returns the word due.
  function automatic merge_word_t merge_pixel(logic signed [DISP_W-1:0] vert,
                                              logic signed [DISP_W-1:0] horiz, logic last);
    merge_word_t     w;
    logic            v_empty;
    logic            h_empty;
    logic            both;
    logic            disagree;
    longint          vq;
    longint          hq;
    longint          d;
    longint unsigned diff;
    longint unsigned whole;
    longint unsigned sh;
    int              res;
    v_empty = (vert == cfg_empty);
    h_empty = (horiz == cfg_empty);
    both    = !v_empty && !h_empty;
    // Whole pixels, then the difference in Q.13 with the ratio applied to the horizontal side.
    vq = longint'(vert >>> SCALE_SHIFT) * (longint'(1) << FRAC_BITS);
    hq = longint'(horiz >>> SCALE_SHIFT) * longint'({48'd0, cfg_ratio});
    d  = vq - hq;
    if (d < 0) diff = -d;
    else diff = d;
    disagree = (diff > cfg_thresh);

    if (cfg_mode == MODE_CONSERVATIVE) begin
      res = (both && !disagree) ? int'(horiz) : int'(cfg_empty);
    end else begin
      if (h_empty) res = v_empty ? int'(cfg_empty) : int'(vert);
      else if (!v_empty) res = disagree ? int'(cfg_empty) : (int'(horiz) + int'(vert)) / 2;
      else res = int'(horiz);
      if (cfg_mode == MODE_DIFF_IMAGE && both) begin
        whole = diff >> FRAC_BITS;
        sh    = (whole > 32767) ? 64'd32767 : (whole << SCALE_SHIFT);
        res   = (sh > 32767) ? 32767 : int'(sh);
      end
    end
    w.merged = 16'(res);

    if (!v_empty) n_vert_valid = bump_count(n_vert_valid);
    if (!h_empty) n_horiz_valid = bump_count(n_horiz_valid);
    if (both) begin
      n_both_valid  = bump_count(n_both_valid);
      diff_total    = sat_accumulate(diff_total, diff, SUM_SAT);
      diff_sq_total = sat_accumulate(diff_sq_total, (diff * diff) >> SQ_DROP, SQ_SAT);
    end
    if (w.merged != cfg_empty) n_merged_valid = bump_count(n_merged_valid);

    w.vert_cnt   = n_vert_valid[CNT_W-1:0];
    w.horiz_cnt  = n_horiz_valid[CNT_W-1:0];
    w.merged_cnt = n_merged_valid[CNT_W-1:0];
    w.both_cnt   = n_both_valid[CNT_W-1:0];
    w.diff_sum   = diff_total[SUM_W-1:0];
    w.sq_sum     = diff_sq_total[SQ_SUM_W-1:0];
    w.last       = last;

    // Statistics restart after the frame-end pixel.
    if (last) begin
      n_vert_valid   = 0;
      n_horiz_valid  = 0;
      n_merged_valid = 0;
      n_both_valid   = 0;
      diff_total     = 0;
      diff_sq_total  = 0;
    end
    return w;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Predicts each accepted pixel and checks each accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    merge_word_t want;
    merge_word_t seen;
    if (pix_valid && pix_ready) begin
      want = merge_pixel(pix_data[15:0], pix_data[31:16], pix_last);
      if (pix_typed) want.merged = pix_typed_merged;
      pending_words.push_back(want);
    end
    if (res_valid && res_ready) begin
      seen.merged     = res_data[0 +: DISP_W];
      seen.vert_cnt   = res_data[DISP_W +: CNT_W];
      seen.horiz_cnt  = res_data[DISP_W + CNT_W +: CNT_W];
      seen.merged_cnt = res_data[DISP_W + 2 * CNT_W +: CNT_W];
      seen.both_cnt   = res_data[DISP_W + 3 * CNT_W +: CNT_W];
      seen.diff_sum   = res_data[DISP_W + 4 * CNT_W +: SUM_W];
      seen.sq_sum     = res_data[DISP_W + 4 * CNT_W + SUM_W +: SQ_SUM_W];
      seen.last       = res_last;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("word received with no pixel pending");
      end else begin
        want = pending_words.pop_front();
        check_field("merged_disp", want.merged, seen.merged);
        check_field("vert_valid_count", want.vert_cnt, seen.vert_cnt);
        check_field("horiz_valid_count", want.horiz_cnt, seen.horiz_cnt);
        check_field("merged_valid_count", want.merged_cnt, seen.merged_cnt);
        check_field("both_valid_count", want.both_cnt, seen.both_cnt);
        check_field("diff_sum", want.diff_sum, seen.diff_sum);
        check_field("diff_square_sum", want.sq_sum, seen.sq_sum);
        check_field("last_out", want.last, seen.last);
        check_field("zero fill", 0, res_data[OUT_BYTES_W-1:OUT_W]);
      end
    end
  end

  // Cycles since the last word moved on either side.
  always @(posedge clk_i) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk_i);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("stereo_disparity_merge: mismatch");
    $finish;
  end

  // Result side: a random stall before each word while recv_idle is set, or none otherwise.
  initial begin
    int stall;
    res_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = recv_idle ? int'($urandom_range(0, 15)) : 0;
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready <= 1'b1;
      @(posedge clk_i);
      while (!res_valid) @(posedge clk_i);
    end
  end

  // Offers one pixel, after a random gap while send_idle is set, and returns at the edge that takes it.
  task automatic send_pixel(logic [DISP_W-1:0] vert, logic [DISP_W-1:0] horiz, logic last,
                            logic typed, logic [DISP_W-1:0] merged);
    int gap;
    gap = send_idle ? int'($urandom_range(0, 15)) : 0;
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_data         <= {horiz, vert};
    pix_last         <= last;
    pix_typed        <= typed;
    pix_typed_merged <= merged;
    pix_valid        <= 1'b1;
    @(posedge clk_i);
    while (!pix_ready) @(posedge clk_i);
  endtask

  // Stops offering pixels and waits for every predicted word to come back.
  task automatic await_drain();
    pix_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Writes a register once the block has gone idle and mirrors it in the shadow copy.
  task automatic write_reg(cfg_index_e idx, logic [CFG_DATA_W-1:0] value);
    await_drain();
    repeat (DRAIN_PAUSE) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      CFG_RATIO:  cfg_ratio  = value[RATIO_W-1:0];
      CFG_THRESH: cfg_thresh = value[THRESH_W-1:0];
      CFG_MODE:   cfg_mode   = value[MODE_W-1:0];
      CFG_EMPTY:  cfg_empty  = value[DISP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly pairs whose difference lies near the threshold, with empty and wild ones mixed in.
  task automatic send_random_pixel();
    int                hw;
    int                vw;
    int                span;
    int                pick;
    longint            scaled;
    logic [DISP_W-1:0] vert;
    logic [DISP_W-1:0] horiz;
    logic              last;
    pick   = $urandom_range(0, 9);
    hw     = int'($urandom_range(0, 4095)) - 2048;
    scaled = (longint'(hw) * longint'({48'd0, cfg_ratio})) >>> FRAC_BITS;
    span   = ((cfg_thresh >> FRAC_BITS) > 60) ? 62 : int'(cfg_thresh >> FRAC_BITS) + 2;
    vw     = int'(scaled) + int'($urandom_range(0, 2 * span)) - span;
    if (vw > 2047) vw = 2047;
    if (vw < -2048) vw = -2048;
    vert  = 16'(vw << SCALE_SHIFT) | 16'($urandom_range(0, 15));
    horiz = 16'(hw << SCALE_SHIFT) | 16'($urandom_range(0, 15));
    case (pick)
      0: vert = cfg_empty;
      1: horiz = cfg_empty;
      2: begin
        vert  = cfg_empty;
        horiz = cfg_empty;
      end
      3: begin
        vert  = 16'($urandom_range(0, 65535));
        horiz = 16'($urandom_range(0, 65535));
      end
      default: ;
    endcase
    last = ($urandom_range(0, 39) == 0);
    send_pixel(vert, horiz, last, 1'b0, 16'd0);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    pix_data         <= '0;
    pix_last         <= 1'b0;
    pix_valid        <= 1'b0;
    pix_typed        <= 1'b0;
    pix_typed_merged <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_RATIO;
    cfg_data         <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].is_write)
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      else
        send_pixel(DIRECTED[i].vert, DIRECTED[i].horiz, DIRECTED[i].last,
                   DIRECTED[i].typed, DIRECTED[i].merged);
    end

    // Random phases, each with fresh settings and its own idling pattern.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: write_reg(CFG_RATIO, 28'd0);
        1: write_reg(CFG_RATIO, 28'hFFFF);
        2: write_reg(CFG_RATIO, 28'($urandom_range(0, 65535)));
        default: write_reg(CFG_RATIO, 28'($urandom_range(4096, 16384)));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(CFG_THRESH, 28'd0);
        1: write_reg(CFG_THRESH, 28'hFFFFFFF);
        2: write_reg(CFG_THRESH, 28'($urandom()));
        default: write_reg(CFG_THRESH, 28'($urandom_range(0, 32768)));
      endcase
      write_reg(CFG_MODE, 28'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
        0: write_reg(CFG_EMPTY, 28'h7FFF);
        1: write_reg(CFG_EMPTY, 28'd0);
        2: write_reg(CFG_EMPTY, 28'($urandom_range(0, 65535)));
        default: write_reg(CFG_EMPTY, 28'h8000);
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(110, 130)) send_random_pixel();
    end

    await_drain();
    repeat (DRAIN_PAUSE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("stereo_disparity_merge: match");
    end else begin
      $display("stereo_disparity_merge: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sdm_pkg.sv
rtl/core/sdm_ctrl.sv
rtl/core/sdm_datapath.sv
rtl/core/stereo_disparity_merge.sv
bench/tb.sv
